// ----- design/lca_pkg.sv -----
// lca_pkg: shared widths, label codes, register indexes and types for the
// labelled centroid accumulator. No dependencies.
package lca_pkg;

    // Field and accumulator widths
    localparam int LABEL_W     = 8;
    localparam int CFG_W       = 12;
    localparam int COUNT_W     = 23;
    localparam int SUM_W       = 33;
    localparam int COORD_W     = 11;
    localparam int NUM_CLASSES = 3;
    localparam int NUM_COORDS  = 2 * NUM_CLASSES;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ACTIVE_COLUMNS = 1'b0;
    localparam logic REG_ACTIVE_ROWS    = 1'b1;
    localparam logic [CFG_W-1:0] ACTIVE_COLUMNS_RESET = 12'd640;
    localparam logic [CFG_W-1:0] ACTIVE_ROWS_RESET    = 12'd480;

    // Label codes, one per class: red, blue, green
    localparam logic [LABEL_W-1:0] LABEL_RED   = 8'd1;
    localparam logic [LABEL_W-1:0] LABEL_BLUE  = 8'd2;
    localparam logic [LABEL_W-1:0] LABEL_GREEN = 8'd3;
    localparam logic [NUM_CLASSES-1:0][LABEL_W-1:0] CLASS_LABEL =
        {LABEL_GREEN, LABEL_BLUE, LABEL_RED};

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Serial divider step counter
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    // One queued beat: the label, the frame-end flag and, at frame end,
    // the accumulator snapshot including this pixel
    typedef struct packed {
        logic [LABEL_W-1:0]                  label;
        logic                                frame_end;
        logic [NUM_CLASSES-1:0][COUNT_W-1:0] count;
        logic [NUM_CLASSES-1:0][SUM_W-1:0]   col_sum;
        logic [NUM_CLASSES-1:0][SUM_W-1:0]   row_sum;
    } lca_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } lca_queue_status_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_DIVIDE
    } lca_back_state_t;

endpackage

// ----- design/labeled_centroid_accumulator.sv -----
// Labelled centroid accumulator top level: configuration registers, front,
// queue and back. Depends on lca_pkg, lca_front, lca_queue, lca_back.
// Path: an ordinary pixel passes through the queue and the output register to the
//   m_ port; the last pixel of a frame also waits for the 33-step bit-serial
//   dividers (six lanes running in parallel). Both assume m_ready high.
// Throughput: one pixel per cycle in a frame while the queue has room; the
//   frame-end beat holds the back part while the dividers run, the 2-deep
//   queue takes two more beats, then s_ready drops. m_ready stalls add directly.
// Reset (aresetn, synchronous, active low): counters and sums clear, counts to
//   one, frame size to 640 x 480, queue and output register empty.
module labeled_centroid_accumulator #(
    parameter int MAX_COLUMNS = 2048,
    parameter int MAX_ROWS    = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Pixel input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lca_pkg::LABEL_W-1:0]       s_pixel_label,
    // Result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lca_pkg::LABEL_W-1:0]       m_pixel_out,
    output logic                              m_frame_done,
    output logic [lca_pkg::COORD_W-1:0]       m_red_x,
    output logic [lca_pkg::COORD_W-1:0]       m_red_y,
    output logic [lca_pkg::COORD_W-1:0]       m_blue_x,
    output logic [lca_pkg::COORD_W-1:0]       m_blue_y,
    output logic [lca_pkg::COORD_W-1:0]       m_green_x,
    output logic [lca_pkg::COORD_W-1:0]       m_green_y,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lca_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lca_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lca_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import lca_pkg::*;

    logic [CFG_W-1:0]                   active_columns_reg;
    logic [CFG_W-1:0]                   active_rows_reg;
    logic                               cfg_write;
    logic                               push;
    logic                               pop;
    lca_item_t                          push_item;
    lca_item_t                          head;
    lca_queue_status_t                  queue_status;
    logic [NUM_COORDS-1:0][COORD_W-1:0] m_coord;

    // Register block
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_columns_reg <= ACTIVE_COLUMNS_RESET;
            active_rows_reg    <= ACTIVE_ROWS_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_ACTIVE_COLUMNS: active_columns_reg <= pwdata[CFG_W-1:0];
                REG_ACTIVE_ROWS:    active_rows_reg    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ACTIVE_COLUMNS: prdata = APB_DATA_W'(active_columns_reg);
            REG_ACTIVE_ROWS:    prdata = APB_DATA_W'(active_rows_reg);
            default:            prdata = '0;
        endcase
    end

    lca_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_label  (s_pixel_label),
        .active_columns (active_columns_reg),
        .active_rows    (active_rows_reg),
        .queue_status   (queue_status),
        .push           (push),
        .push_item      (push_item)
    );

    lca_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .push_item    (push_item),
        .pop          (pop),
        .head         (head),
        .queue_status (queue_status)
    );

    lca_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .queue_status (queue_status),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_frame_done (m_frame_done),
        .m_coord      (m_coord)
    );

    // Centroid lanes: x and y per class, red then blue then green
    assign m_red_x   = m_coord[0];
    assign m_red_y   = m_coord[1];
    assign m_blue_x  = m_coord[2];
    assign m_blue_y  = m_coord[3];
    assign m_green_x = m_coord[4];
    assign m_green_y = m_coord[5];

endmodule

// ----- design/lca_front.sv -----
// lca_front: raster position counters and per-class accumulators.
// Depends on lca_pkg; feeds lca_queue.
module lca_front #(
    parameter int MAX_COLUMNS = 2048,
    parameter int MAX_ROWS    = 2048
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [lca_pkg::LABEL_W-1:0]        s_pixel_label,
    input  logic [lca_pkg::CFG_W-1:0]          active_columns,
    input  logic [lca_pkg::CFG_W-1:0]          active_rows,
    input  lca_pkg::lca_queue_status_t         queue_status,
    output logic                               push,
    output lca_pkg::lca_item_t                 push_item
);
    import lca_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam logic [CFG_W:0] MAX_COL_EXT = (CFG_W+1)'(MAX_COLUMNS);
    localparam logic [CFG_W:0] MAX_ROW_EXT = (CFG_W+1)'(MAX_ROWS);

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic             end_row;
    logic             end_frame;
    logic             accept;
    logic [NUM_CLASSES-1:0]              hit;
    logic [NUM_CLASSES-1:0][COUNT_W-1:0] count_reg, count_next;
    logic [NUM_CLASSES-1:0][SUM_W-1:0]   col_sum_reg, col_sum_next;
    logic [NUM_CLASSES-1:0][SUM_W-1:0]   row_sum_reg, row_sum_next;

    assign s_ready = !queue_status.full;
    assign accept  = s_valid && s_ready;

    // Last position: zero size counts as one, oversize saturates
    always_comb begin
        if (active_columns == '0) begin
            last_col = '0;
        end else if ({1'b0, active_columns} > MAX_COL_EXT) begin
            last_col = COL_W'(MAX_COLUMNS - 1);
        end else begin
            last_col = COL_W'(active_columns - 1'b1);
        end
        if (active_rows == '0) begin
            last_row = '0;
        end else if ({1'b0, active_rows} > MAX_ROW_EXT) begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end else begin
            last_row = ROW_W'(active_rows - 1'b1);
        end
    end

    // A counter at or past the last position ends the row or frame
    assign end_row   = col_reg >= last_col;
    assign end_frame = end_row && (row_reg >= last_row);

    // Accumulator update for this pixel (wraps at register width)
    always_comb begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
            hit[k] = s_pixel_label == CLASS_LABEL[k];
            if (hit[k]) begin
                count_next[k]   = count_reg[k] + COUNT_W'(1);
                col_sum_next[k] = col_sum_reg[k] + SUM_W'(col_reg);
                row_sum_next[k] = row_sum_reg[k] + SUM_W'(row_reg);
            end else begin
                count_next[k]   = count_reg[k];
                col_sum_next[k] = col_sum_reg[k];
                row_sum_next[k] = row_sum_reg[k];
            end
        end
    end

    assign push                = accept;
    assign push_item.label     = s_pixel_label;
    assign push_item.frame_end = end_frame;
    assign push_item.count     = count_next;
    assign push_item.col_sum   = col_sum_next;
    assign push_item.row_sum   = row_sum_next;

    // Position counters and accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                count_reg[k]   <= COUNT_W'(1);
                col_sum_reg[k] <= '0;
                row_sum_reg[k] <= '0;
            end
        end else if (accept) begin
            if (end_frame) begin
                col_reg <= '0;
                row_reg <= '0;
                for (int k = 0; k < NUM_CLASSES; k++) begin
                    count_reg[k]   <= COUNT_W'(1);
                    col_sum_reg[k] <= '0;
                    row_sum_reg[k] <= '0;
                end
            end else begin
                count_reg   <= count_next;
                col_sum_reg <= col_sum_next;
                row_sum_reg <= row_sum_next;
                if (end_row) begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

endmodule

// ----- design/lca_queue.sv -----
// lca_queue: short flop-based queue of beats between front and back.
// Depends on lca_pkg.
module lca_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  lca_pkg::lca_item_t         push_item,
    input  logic                       pop,
    output lca_pkg::lca_item_t         head,
    output lca_pkg::lca_queue_status_t queue_status
);
    import lca_pkg::*;

    lca_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;

    assign head               = entry_reg[rd_ptr_reg];
    assign queue_status.empty = fill_reg == '0;
    assign queue_status.full  = fill_reg == (QPTR_W+1)'(QUEUE_DEPTH);

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        queue_status.full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        queue_status.empty |-> !pop)
        else $error("queue read while empty");

endmodule

// ----- design/lca_div.sv -----
// lca_div: restoring divider, one quotient bit per cycle, sum / count.
// Depends on lca_pkg; a zero divisor gives a zero quotient.
module lca_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [lca_pkg::SUM_W-1:0]     dividend,
    input  logic [lca_pkg::COUNT_W-1:0]   divisor,
    output logic                          busy,
    output logic [lca_pkg::COORD_W-1:0]   quotient
);
    import lca_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [COUNT_W-1:0]   den_reg;
    logic                 den_zero_reg;
    logic [COUNT_W:0]     trial;
    logic                 fits;
    logic [COUNT_W-1:0]   rem_next;

    // One restoring step: shift in next dividend bit, subtract if it fits
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign rem_next = fits ? COUNT_W'(trial - {1'b0, den_reg}) : trial[COUNT_W-1:0];

    assign busy     = busy_reg;
    assign quotient = den_zero_reg ? '0 : quo_reg[COORD_W-1:0];

    // Step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(SUM_W);
        end else if (busy_reg) begin
            busy_reg <= cnt_reg != DIV_CNT_W'(1);
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    // Datapath: dividend register fills with quotient bits from the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg      <= dividend;
            rem_reg      <= '0;
            den_reg      <= divisor;
            den_zero_reg <= divisor == '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

endmodule

// ----- design/lca_back.sv -----
// lca_back: drains the queue, runs the per-class dividers at frame end and
// holds the output register. Depends on lca_pkg and lca_div.
module lca_back (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  lca_pkg::lca_item_t                               head,
    input  lca_pkg::lca_queue_status_t                       queue_status,
    output logic                                             pop,
    output logic                                             m_valid,
    input  logic                                             m_ready,
    output logic [lca_pkg::LABEL_W-1:0]                      m_pixel_out,
    output logic                                             m_frame_done,
    output logic [lca_pkg::NUM_COORDS-1:0][lca_pkg::COORD_W-1:0] m_coord
);
    import lca_pkg::*;

    lca_back_state_t state_reg, state_next;
    logic                                m_valid_reg;
    logic [LABEL_W-1:0]                  m_pixel_reg;
    logic                                m_frame_done_reg;
    logic [NUM_COORDS-1:0][COORD_W-1:0]  m_coord_reg;
    logic [LABEL_W-1:0]                  label_hold_reg;
    logic                                out_free;
    logic                                div_start;
    logic                                load_pixel;
    logic                                load_result;
    logic [NUM_COORDS-1:0]               div_busy;
    logic [NUM_COORDS-1:0][COORD_W-1:0]  div_q;

    // Two dividers per class: x from column sum, y from row sum
    for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_class
        lca_div u_div_x (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (div_start),
            .dividend (head.col_sum[k]),
            .divisor  (head.count[k]),
            .busy     (div_busy[2*k]),
            .quotient (div_q[2*k])
        );
        lca_div u_div_y (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (div_start),
            .dividend (head.row_sum[k]),
            .divisor  (head.count[k]),
            .busy     (div_busy[2*k+1]),
            .quotient (div_q[2*k+1])
        );
    end

    assign out_free = !m_valid_reg || m_ready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BACK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and control
    always_comb begin
        state_next  = state_reg;
        pop         = 1'b0;
        div_start   = 1'b0;
        load_pixel  = 1'b0;
        load_result = 1'b0;
        case (state_reg)
            BACK_IDLE: begin
                if (!queue_status.empty) begin
                    if (!head.frame_end) begin
                        if (out_free) begin
                            pop        = 1'b1;
                            load_pixel = 1'b1;
                        end
                    end else begin
                        pop        = 1'b1;
                        div_start  = 1'b1;
                        state_next = BACK_DIVIDE;
                    end
                end
            end
            BACK_DIVIDE: begin
                if (div_busy == '0 && out_free) begin
                    load_result = 1'b1;
                    state_next  = BACK_IDLE;
                end
            end
            default: begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_pixel || load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            label_hold_reg <= head.label;
        end
        if (load_pixel) begin
            m_pixel_reg      <= head.label;
            m_frame_done_reg <= 1'b0;
            m_coord_reg      <= '0;
        end else if (load_result) begin
            m_pixel_reg      <= label_hold_reg;
            m_frame_done_reg <= 1'b1;
            m_coord_reg      <= div_q;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = m_pixel_reg;
    assign m_frame_done = m_frame_done_reg;
    assign m_coord      = m_coord_reg;

    a_hold_queue_while_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BACK_DIVIDE |-> !pop)
        else $error("queue popped while dividers run");

    a_dividers_start_together: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> &div_busy)
        else $error("divider lanes not all busy after start");

    a_result_after_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |-> div_busy == '0)
        else $error("centroid loaded before division finished");

    a_coords_zero_off_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_frame_done_reg |-> m_coord_reg == '0)
        else $error("centroid fields non-zero on ordinary pixel");

endmodule

// ----- dv/tb_labeled_centroid_accumulator.sv -----
`timescale 1ns / 100ps
// tb_labeled_centroid_accumulator: self-checking bench for the labelled centroid accumulator.
// Streams label pixels, predicts every result beat and the frame-end centroids, checks them.
// Depends on lca_pkg and labeled_centroid_accumulator.
module tb_labeled_centroid_accumulator;
    import lca_pkg::*;

    localparam int MAX_COLUMNS     = 2048;
    localparam int MAX_ROWS        = 2048;
    localparam int OVERSIZE_PIXELS = 100;
    localparam int RANDOM_PIXELS   = 1680;
    localparam int CYCLE_LIMIT     = 4_000_000;
    localparam int DRAIN_TAIL      = 50;
    localparam int REPORT_LIMIT    = 10;

    // One result beat; coord order is red_x, red_y, blue_x, blue_y, green_x, green_y
    typedef struct packed {
        logic [LABEL_W-1:0]                 pixel;
        logic                               frame_done;
        logic [NUM_COORDS-1:0][COORD_W-1:0] coord;
    } centroid_beat_t;

    // Centroid predictor and result checker
    class centroid_scoreboard;
        logic [CFG_W-1:0]   active_columns;
        logic [CFG_W-1:0]   active_rows;
        int unsigned        col_pos;
        int unsigned        row_pos;
        logic [COUNT_W-1:0] pixel_count [NUM_CLASSES];
        logic [SUM_W-1:0]   col_sum [NUM_CLASSES];
        logic [SUM_W-1:0]   row_sum [NUM_CLASSES];
        centroid_beat_t     expected_q [$];
        string              coord_name [NUM_COORDS];
        int unsigned        pixels_noted;
        int unsigned        results_seen;
        int unsigned        frames_seen;
        int unsigned        failures;

        function new();
            active_columns = ACTIVE_COLUMNS_RESET;
            active_rows    = ACTIVE_ROWS_RESET;
            col_pos        = 0;
            row_pos        = 0;
            pixels_noted   = 0;
            results_seen   = 0;
            frames_seen    = 0;
            failures       = 0;
            coord_name = '{"red_x", "red_y", "blue_x", "blue_y", "green_x", "green_y"};
            clear_classes();
        endfunction

        // Counts restart at one so the divisor is pixels plus one
        function void clear_classes();
            for (int k = 0; k < NUM_CLASSES; k++) begin
                pixel_count[k] = 1;
                col_sum[k]     = '0;
                row_sum[k]     = '0;
            end
        endfunction

        function void set_register(logic reg_index, logic [APB_DATA_W-1:0] value);
            if (reg_index == REG_ACTIVE_COLUMNS) active_columns = value[CFG_W-1:0];
            else active_rows = value[CFG_W-1:0];
        endfunction

        function logic [CFG_W-1:0] register_value(logic reg_index);
            return (reg_index == REG_ACTIVE_COLUMNS) ? active_columns : active_rows;
        endfunction

        // Zero size acts as one, oversize saturates at the maximum
        function int unsigned last_index(logic [CFG_W-1:0] size, int unsigned limit);
            if (size == 0) return 0;
            if (size > limit) return limit - 1;
            return size - 1;
        endfunction

        // Truncating quotient, zero for a wrapped count, kept to coordinate width
        function logic [COORD_W-1:0] centroid(logic [SUM_W-1:0] total,
                                              logic [COUNT_W-1:0] count);
            logic [SUM_W-1:0] q;
            if (count == 0) return '0;
            q = total / SUM_W'(count);
            return q[COORD_W-1:0];
        endfunction

        // Accepted pixel: update accumulators and queue the beat it must produce
        function void note_pixel(logic [LABEL_W-1:0] label);
            centroid_beat_t beat;
            int unsigned    last_col;
            int unsigned    last_row;
            bit             row_end;
            bit             frame_end;
            last_col  = last_index(active_columns, MAX_COLUMNS);
            last_row  = last_index(active_rows, MAX_ROWS);
            row_end   = col_pos >= last_col;
            frame_end = row_end && (row_pos >= last_row);
            beat       = '0;
            beat.pixel = label;
            pixels_noted++;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                if (label == CLASS_LABEL[k]) begin
                    pixel_count[k] = pixel_count[k] + 1'b1;
                    col_sum[k]     = col_sum[k] + col_pos;
                    row_sum[k]     = row_sum[k] + row_pos;
                end
            end
            if (frame_end) begin
                beat.frame_done = 1'b1;
                for (int k = 0; k < NUM_CLASSES; k++) begin
                    beat.coord[2*k]   = centroid(col_sum[k], pixel_count[k]);
                    beat.coord[2*k+1] = centroid(row_sum[k], pixel_count[k]);
                end
                clear_classes();
                col_pos = 0;
                row_pos = 0;
            end else if (row_end) begin
                col_pos = 0;
                row_pos++;
            end else begin
                col_pos++;
            end
            expected_q.push_back(beat);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("MISMATCH %s at beat %0d: expected %0d, got %0d",
                         field, results_seen, want, got);
        endfunction

        // Accepted result beat against the oldest expectation
        function void check_result(centroid_beat_t got);
            centroid_beat_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report("unexpected beat, pixel_out", '0, got.pixel);
                return;
            end
            want = expected_q.pop_front();
            if (got.frame_done === 1'b1) frames_seen++;
            if (got.pixel !== want.pixel) report("pixel_out", want.pixel, got.pixel);
            if (got.frame_done !== want.frame_done)
                report("frame_done", want.frame_done, got.frame_done);
            for (int k = 0; k < NUM_COORDS; k++)
                if (got.coord[k] !== want.coord[k])
                    report(coord_name[k], want.coord[k], got.coord[k]);
        endfunction

        function void finish_check();
            if (expected_q.size() != 0) begin
                failures += expected_q.size();
                $display("%0d expected beats never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [LABEL_W-1:0]    s_pixel_label;
    logic                  m_valid;
    logic                  m_ready;
    logic [LABEL_W-1:0]    m_pixel_out;
    logic                  m_frame_done;
    logic [COORD_W-1:0]    m_red_x;
    logic [COORD_W-1:0]    m_red_y;
    logic [COORD_W-1:0]    m_blue_x;
    logic [COORD_W-1:0]    m_blue_y;
    logic [COORD_W-1:0]    m_green_x;
    logic [COORD_W-1:0]    m_green_y;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    centroid_scoreboard sb;
    bit                 steady_flow = 1'b1;
    int unsigned        register_writes = 0;
    int unsigned        cycle_count;

    labeled_centroid_accumulator #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_label (s_pixel_label),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_frame_done  (m_frame_done),
        .m_red_x       (m_red_x),
        .m_red_y       (m_red_y),
        .m_blue_x      (m_blue_x),
        .m_blue_y      (m_blue_y),
        .m_green_x     (m_green_x),
        .m_green_y     (m_green_y),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle length: mostly short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Mostly class labels and background, some arbitrary bytes
    function automatic logic [LABEL_W-1:0] random_label();
        if ($urandom_range(0, 99) < 88) return LABEL_W'($urandom_range(0, LABEL_GREEN));
        return LABEL_W'($urandom_range(0, (1 << LABEL_W) - 1));
    endfunction

    // Frame dimension: small mostly, zero and one often; junk in the unused bits at times
    function automatic logic [APB_DATA_W-1:0] random_size();
        int unsigned           r;
        logic [APB_DATA_W-1:0] size;
        r = $urandom_range(0, 99);
        if (r < 8) size = 0;
        else if (r < 22) size = 1;
        else if (r < 85) size = $urandom_range(2, 8);
        else size = $urandom_range(9, 40);
        if ($urandom_range(0, 99) < 20) size = size | ($urandom() << CFG_W);
        return size;
    endfunction

    // Register access; a write is followed back to back by a read of the same register
    task automatic access_register(input logic reg_index, input bit do_write,
                                   input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= do_write;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (do_write) begin
            sb.set_register(reg_index, value);
            register_writes++;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (pready !== 1'b1);
        end
        readback = prdata;
        if (readback[CFG_W-1:0] !== sb.register_value(reg_index))
            sb.report(reg_index == REG_ACTIVE_COLUMNS ? "active_columns" : "active_rows",
                      sb.register_value(reg_index), readback[CFG_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // One beat on the pixel input; returns at the accepting edge
    task automatic send_pixel(input logic [LABEL_W-1:0] label);
        s_valid       <= 1'b1;
        s_pixel_label <= label;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_pixel(label);
    endtask

    task automatic sender_gap();
        int unsigned idle;
        if (steady_flow || $urandom_range(0, 99) >= 25) return;
        idle = pick_gap();
        s_valid <= 1'b0;
        repeat (idle) @(posedge aclk);
    endtask

    task automatic stream_pixels(input int unsigned n);
        repeat (n) begin
            send_pixel(random_label());
            sender_gap();
        end
    endtask

    // Hold the input until every predicted beat has come out
    task automatic pause_sender();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_q.size() != 0);
    endtask

    // Result side: check accepted beats, stall at random
    initial begin : result_sink
        centroid_beat_t got;
        int unsigned    stall;
        stall   = 0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                got.pixel      = m_pixel_out;
                got.frame_done = m_frame_done;
                got.coord[0]   = m_red_x;
                got.coord[1]   = m_red_y;
                got.coord[2]   = m_blue_x;
                got.coord[3]   = m_blue_y;
                got.coord[4]   = m_green_x;
                got.coord[5]   = m_green_y;
                sb.check_result(got);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 99) < 20) stall = pick_gap();
            end
            @(posedge aclk);
        end
    end

    // Watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Run stopped at cycle limit with %0d beats outstanding", sb.expected_q.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned           random_count;
        int unsigned           phase;
        int unsigned           span;
        int unsigned           half;
        bit                    write_cols;
        bit                    write_rows;
        logic [APB_DATA_W-1:0] cols;
        logic [APB_DATA_W-1:0] rows;
        sb            = new();
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_pixel_label <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values of both registers
        access_register(REG_ACTIVE_COLUMNS, 1'b0, '0);
        access_register(REG_ACTIVE_ROWS, 1'b0, '0);

        // Each class once at the head of a reset-size frame
        send_pixel(LABEL_RED);
        send_pixel(LABEL_BLUE);
        send_pixel(LABEL_GREEN);

        // Shrink to 2 x 2 mid-frame: the column is already past the new row end
        pause_sender();
        access_register(REG_ACTIVE_COLUMNS, 1'b1, 2);
        access_register(REG_ACTIVE_ROWS, 1'b1, 2);
        send_pixel('1);
        send_pixel('0);
        send_pixel(LABEL_GREEN + 1'b1);

        // Frame with no class pixels at all
        repeat (4) send_pixel('0);

        // Zero sizes act as one: every pixel is a whole frame
        pause_sender();
        access_register(REG_ACTIVE_COLUMNS, 1'b1, 0);
        access_register(REG_ACTIVE_ROWS, 1'b1, 0);
        send_pixel(LABEL_RED);
        send_pixel(LABEL_BLUE);
        send_pixel(LABEL_GREEN);
        send_pixel('1);

        // One column, three rows
        pause_sender();
        access_register(REG_ACTIVE_COLUMNS, 1'b1, 1);
        access_register(REG_ACTIVE_ROWS, 1'b1, 3);
        send_pixel(LABEL_BLUE);
        send_pixel(LABEL_GREEN);
        send_pixel(LABEL_RED);

        // Oversize registers saturate: a long first row that the next size
        // change cuts short, so its sums land in a small frame's centroids
        steady_flow = 1'b0;
        pause_sender();
        access_register(REG_ACTIVE_COLUMNS, 1'b1, '1);
        access_register(REG_ACTIVE_ROWS, 1'b1, '1);
        stream_pixels(OVERSIZE_PIXELS);

        // Random sizes; phases stop at arbitrary points, so sizes also change mid-frame
        random_count = 0;
        phase        = 0;
        while (random_count < RANDOM_PIXELS) begin
            pause_sender();
            cols       = random_size();
            rows       = random_size();
            write_cols = $urandom_range(0, 3) != 0;
            write_rows = !write_cols || ($urandom_range(0, 1) != 0);
            if (write_cols) access_register(REG_ACTIVE_COLUMNS, 1'b1, cols);
            if (write_rows) access_register(REG_ACTIVE_ROWS, 1'b1, rows);
            steady_flow = $urandom_range(0, 99) < 20;
            span = (sb.last_index(sb.active_columns, MAX_COLUMNS) + 1)
                 * (sb.last_index(sb.active_rows, MAX_ROWS) + 1)
                 * $urandom_range(1, 3) + $urandom_range(0, 4);
            if (span > 160) span = $urandom_range(40, 160);
            if (phase == 0 || $urandom_range(0, 99) < 15) begin
                // hold the input mid-phase until the output side has caught up
                half = span / 2;
                stream_pixels(half);
                pause_sender();
                stream_pixels(span - half);
            end else begin
                stream_pixels(span);
            end
            random_count += span;
            phase++;
        end

        // Drain and let the dividers settle
        pause_sender();
        repeat (DRAIN_TAIL) @(posedge aclk);
        sb.finish_check();

        $display("Streamed %0d pixels (%0d random over %0d size phases), %0d register writes.",
                 sb.pixels_noted, random_count, phase, register_writes);
        $display("Checked %0d result beats, %0d of them frame ends; %0d failures.",
                 sb.results_seen, sb.frames_seen, sb.failures);
        if (sb.failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- labeled_centroid_accumulator.f -----
design/lca_pkg.sv
design/lca_front.sv
design/lca_queue.sv
design/lca_div.sv
design/lca_back.sv
design/labeled_centroid_accumulator.sv
dv/tb_labeled_centroid_accumulator.sv
